@@ sv/barometric_pressure_compensation_unit_defines.svh @@
// Assertion macros used by the property checker of this block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// Implication checked at every rising edge of clk outside reset.
`define BPC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc implication failed");

// Condition that must never hold outside reset.
`define BPC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bpc forbidden condition seen");

`endif

@@ sv/bpc_pkg.sv @@
package bpc_pkg;

  localparam int DIV_W = 32;

  // Clock edges from the edge that accepts a transaction to the edge that takes its result.
  localparam int LATENCY = 78;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MB_MC   = 3'd4,
    REG_MD      = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] C_4000     = 32'd4000;
  localparam logic [31:0] C_32768    = 32'd32768;
  localparam logic [31:0] C_50000    = 32'd50000;
  localparam logic [31:0] C_3038     = 32'd3038;
  localparam logic [31:0] C_NEG_7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791     = 32'd3791;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ sv/bpc_div.sv @@
module bpc_div #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [bpc_pkg::DIV_W-1:0]     in_dividend,
  input  logic [bpc_pkg::DIV_W-1:0]     in_divisor,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [bpc_pkg::DIV_W-1:0]     out_quot,
  output logic [SW-1:0]                 out_side
);

  localparam int W = bpc_pkg::DIV_W;

  // One quotient bit per stage; the dividend shifts out of dq as the quotient shifts in.
  logic [W-1:0]  vld_r;
  logic [W-1:0]  rem_r  [W];
  logic [W-1:0]  dq_r   [W];
  logic [W-1:0]  dv_r   [W];
  logic [SW-1:0] side_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          s_vld;
    logic [W-1:0]  s_rem;
    logic [W-1:0]  s_dq;
    logic [W-1:0]  s_dv;
    logic [SW-1:0] s_side;
    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  rem_nxt;
    logic [W-1:0]  dq_nxt;

    if (k == 0) begin : g_first
      assign s_vld  = in_valid;
      assign s_rem  = '0;
      assign s_dq   = in_dividend;
      assign s_dv   = in_divisor;
      assign s_side = in_side;
    end else begin : g_next
      assign s_vld  = vld_r[k-1];
      assign s_rem  = rem_r[k-1];
      assign s_dq   = dq_r[k-1];
      assign s_dv   = dv_r[k-1];
      assign s_side = side_r[k-1];
    end

    always_comb begin
      trial   = {s_rem, s_dq[W-1]};
      ge      = (trial >= {1'b0, s_dv});
      rem_nxt = ge ? W'(trial - {1'b0, s_dv}) : trial[W-1:0];
      dq_nxt  = {s_dq[W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= s_vld;
      end
      rem_r[k]  <= rem_nxt;
      dq_r[k]   <= dq_nxt;
      dv_r[k]   <= s_dv;
      side_r[k] <= s_side;
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_quot  = dq_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

@@ sv/barometric_pressure_compensation_unit.sv @@
// Barometric compensation pipeline. A transaction is accepted whenever start is high; busy is
// always low, so a new pair of raw readings may enter on every clock cycle. Each transaction
// gives exactly one result, shown on the out_ ports for a single cycle with out_valid high.
// The pipeline holds two 32-stage restoring dividers (temperature correction and pressure
// quotient) plus the multiplier stages around them. The receiver cannot stall the block,
// so results must be taken when strobed. The calibration registers are read live and must
// only be written while no transaction is in flight. When a divisor is zero, out_div_error
// is set and both results are zero.
module barometric_pressure_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_raw_temp,
  input  logic [15:0] in_raw_pres,
  output logic        out_valid,
  output logic signed [31:0] out_temp_tenths,
  output logic signed [31:0] out_pressure_pa,
  output logic        out_div_error,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int W = bpc_pkg::DIV_W;

  logic [31:0] cal_ac1_ac2_r, cal_ac3_ac4_r, cal_ac5_ac6_r, cal_b1_b2_r, cal_mb_mc_r;
  logic [15:0] cal_md_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_ac1_ac2_r <= '0;
      cal_ac3_ac4_r <= '0;
      cal_ac5_ac6_r <= '0;
      cal_b1_b2_r   <= '0;
      cal_mb_mc_r   <= '0;
      cal_md_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: cal_ac1_ac2_r <= cfg_wdata;
        bpc_pkg::REG_AC3_AC4: cal_ac3_ac4_r <= cfg_wdata;
        bpc_pkg::REG_AC5_AC6: cal_ac5_ac6_r <= cfg_wdata;
        bpc_pkg::REG_B1_B2:   cal_b1_b2_r   <= cfg_wdata;
        bpc_pkg::REG_MB_MC:   cal_mb_mc_r   <= cfg_wdata;
        bpc_pkg::REG_MD:      cal_md_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(cal_ac1_ac2_r[31:16]);
  assign ac2 = bpc_pkg::sx16(cal_ac1_ac2_r[15:0]);
  assign ac3 = bpc_pkg::sx16(cal_ac3_ac4_r[31:16]);
  assign ac4 = {16'b0, cal_ac3_ac4_r[15:0]};
  assign ac5 = {16'b0, cal_ac5_ac6_r[31:16]};
  assign ac6 = {16'b0, cal_ac5_ac6_r[15:0]};
  assign b1  = bpc_pkg::sx16(cal_b1_b2_r[31:16]);
  assign b2  = bpc_pkg::sx16(cal_b1_b2_r[15:0]);
  assign mc  = bpc_pkg::sx16(cal_mb_mc_r[15:0]);
  assign md  = bpc_pkg::sx16(cal_md_r);

  assign busy = 1'b0;

  // Temperature front end.
  logic        a_vld_r, b_vld_r, c_vld_r;
  logic [31:0] a_d_r, b_m_r;
  logic [15:0] a_up_r, b_up_r, c_up_r;
  logic [31:0] c_x1_r, c_ua_r, c_ub_r;
  logic        c_zero_r, c_neg_r;
  logic [31:0] x1_t, den_t, num_t;

  always_comb begin
    x1_t  = 32'($signed(b_m_r) >>> 15);
    den_t = x1_t + md;
    num_t = {mc[20:0], 11'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    a_d_r    <= {16'b0, in_raw_temp} - ac6;
    a_up_r   <= in_raw_pres;
    b_m_r    <= a_d_r * ac5;
    b_up_r   <= a_up_r;
    c_x1_r   <= x1_t;
    c_zero_r <= (den_t == '0);
    c_neg_r  <= num_t[31] ^ den_t[31];
    c_ua_r   <= num_t[31] ? 32'(-num_t) : num_t;
    c_ub_r   <= den_t[31] ? 32'(-den_t) : den_t;
    c_up_r   <= b_up_r;
  end

  localparam int SW1 = 32 + 1 + 1 + 16;
  logic           d1_vld;
  logic [W-1:0]   d1_q;
  logic [SW1-1:0] d1_side;

  bpc_div #(.SW(SW1)) u_div_temp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (c_vld_r),
    .in_dividend(c_ua_r),
    .in_divisor (c_ub_r),
    .in_side    ({c_x1_r, c_zero_r, c_neg_r, c_up_r}),
    .out_valid  (d1_vld),
    .out_quot   (d1_q),
    .out_side   (d1_side)
  );

  // Pressure coefficient stages.
  logic        d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r, j_vld_r;
  logic [31:0] d_t_r, e_t_r, f_t_r, g_t_r, h_t_r, i_t_r, j_t_r;
  logic        d_err_r, e_err_r, f_err_r, g_err_r, h_err_r, i_err_r, j_err_r;
  logic [15:0] d_up_r, e_up_r, f_up_r, g_up_r, h_up_r, i_up_r;
  logic [31:0] d_b6_r;
  logic [31:0] e_sqp_r, e_p1_r, e_p2_r;
  logic [31:0] f_sq_r, f_x1a_r, f_x1c_r;
  logic [31:0] g_m3_r, g_m4_r, g_x1a_r, g_x1c_r;
  logic [31:0] h_b3n_r, h_x3b_r;
  logic [31:0] i_b3_r, i_m5_r;
  logic [31:0] j_b4_r, j_b7_r;
  logic [31:0] x2_t, b5_t, x3b_t, b3_t;

  always_comb begin
    x2_t  = d1_side[16] ? 32'(-d1_q) : d1_q;
    b5_t  = d1_side[49:18] + x2_t;
    x3b_t = g_x1c_r + 32'($signed(g_m4_r) >>> 16) + 32'd2;
    // Division by four truncating toward zero.
    b3_t  = h_b3n_r[31] ? 32'($signed(h_b3n_r + 32'd3) >>> 2)
                        : 32'($signed(h_b3n_r) >>> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
    end else begin
      d_vld_r <= d1_vld;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
    end
    d_t_r   <= 32'($signed(b5_t + 32'd8) >>> 4);
    d_b6_r  <= b5_t - bpc_pkg::C_4000;
    d_err_r <= d1_side[17];
    d_up_r  <= d1_side[15:0];

    e_sqp_r <= d_b6_r * d_b6_r;
    e_p1_r  <= ac2 * d_b6_r;
    e_p2_r  <= ac3 * d_b6_r;
    e_t_r   <= d_t_r;
    e_err_r <= d_err_r;
    e_up_r  <= d_up_r;

    f_sq_r  <= 32'($signed(e_sqp_r) >>> 12);
    f_x1a_r <= 32'($signed(e_p1_r) >>> 11);
    f_x1c_r <= 32'($signed(e_p2_r) >>> 13);
    f_t_r   <= e_t_r;
    f_err_r <= e_err_r;
    f_up_r  <= e_up_r;

    g_m3_r  <= b2 * f_sq_r;
    g_m4_r  <= b1 * f_sq_r;
    g_x1a_r <= f_x1a_r;
    g_x1c_r <= f_x1c_r;
    g_t_r   <= f_t_r;
    g_err_r <= f_err_r;
    g_up_r  <= f_up_r;

    h_b3n_r <= {ac1[29:0], 2'b0} + 32'($signed(g_m3_r) >>> 11) + g_x1a_r + 32'd2;
    h_x3b_r <= 32'($signed(x3b_t) >>> 2);
    h_t_r   <= g_t_r;
    h_err_r <= g_err_r;
    h_up_r  <= g_up_r;

    i_b3_r  <= b3_t;
    i_m5_r  <= ac4 * (h_x3b_r + bpc_pkg::C_32768);
    i_t_r   <= h_t_r;
    i_err_r <= h_err_r;
    i_up_r  <= h_up_r;

    j_b4_r  <= i_m5_r >> 15;
    j_b7_r  <= ({16'b0, i_up_r} - i_b3_r) * bpc_pkg::C_50000;
    j_t_r   <= i_t_r;
    j_err_r <= i_err_r;
  end

  // b7 at or above 2^31 is divided first and doubled afterwards.
  localparam int SW2 = 32 + 1 + 1;
  logic           d2_vld;
  logic [W-1:0]   d2_q;
  logic [SW2-1:0] d2_side;
  logic [W-1:0]   d2_dividend;

  assign d2_dividend = j_b7_r[31] ? j_b7_r : {j_b7_r[30:0], 1'b0};

  bpc_div #(.SW(SW2)) u_div_pres (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (j_vld_r),
    .in_dividend(d2_dividend),
    .in_divisor (j_b4_r),
    .in_side    ({j_t_r, j_err_r || (j_b4_r == '0), j_b7_r[31]}),
    .out_valid  (d2_vld),
    .out_quot   (d2_q),
    .out_side   (d2_side)
  );

  // Final pressure correction.
  logic        k_vld_r, l_vld_r, m_vld_r;
  logic [31:0] k_p_r, l_p_r, m_p_r;
  logic [31:0] k_t_r, l_t_r, m_t_r;
  logic        k_err_r, l_err_r, m_err_r;
  logic [31:0] l_m6_r, l_m7_r, m_m8_r, m_x2_r;
  logic [31:0] ps_t, corr_t;

  always_comb begin
    ps_t   = 32'($signed(k_p_r) >>> 8);
    corr_t = 32'($signed(m_m8_r) >>> 16) + m_x2_r + bpc_pkg::C_3791;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
      l_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else begin
      k_vld_r <= d2_vld;
      l_vld_r <= k_vld_r;
      m_vld_r <= l_vld_r;
    end
    k_p_r   <= d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
    k_t_r   <= d2_side[33:2];
    k_err_r <= d2_side[1];

    l_m6_r  <= ps_t * ps_t;
    l_m7_r  <= bpc_pkg::C_NEG_7357 * k_p_r;
    l_p_r   <= k_p_r;
    l_t_r   <= k_t_r;
    l_err_r <= k_err_r;

    m_m8_r  <= l_m6_r * bpc_pkg::C_3038;
    m_x2_r  <= 32'($signed(l_m7_r) >>> 16);
    m_p_r   <= l_p_r;
    m_t_r   <= l_t_r;
    m_err_r <= l_err_r;
  end

  logic        out_valid_r, out_div_error_r;
  logic [31:0] out_temp_r, out_pres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      out_div_error_r <= 1'b0;
    end else begin
      out_valid_r     <= m_vld_r;
      out_div_error_r <= m_vld_r && m_err_r;
    end
    out_temp_r <= m_err_r ? '0 : m_t_r;
    out_pres_r <= m_err_r ? '0 : m_p_r + 32'($signed(corr_t) >>> 4);
  end

  assign out_valid       = out_valid_r;
  assign out_div_error   = out_div_error_r;
  assign out_temp_tenths = $signed(out_temp_r);
  assign out_pressure_pa = $signed(out_pres_r);

endmodule

@@ sv/bpc_checker.sv @@
`include "barometric_pressure_compensation_unit_defines.svh"

module bpc_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_raw_temp,
  input logic [15:0] in_raw_pres,
  input logic        out_valid,
  input logic signed [31:0] out_temp_tenths,
  input logic signed [31:0] out_pressure_pa,
  input logic        out_div_error,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_wdata
);

  // Every result strobe traces back to an earlier accepted transaction.
  `BPC_ASSERT_IMPLY(a_result_has_cause, out_valid, $past(start && !busy, bpc_pkg::LATENCY))

  // A failed division always gives zero results.
  `BPC_ASSERT_IMPLY(a_error_zeroes, out_valid && out_div_error,
                    (out_temp_tenths == 0) && (out_pressure_pa == 0))

  `BPC_ASSERT_IMPLY(a_error_with_strobe, out_div_error, out_valid)

  `BPC_ASSERT_NEVER(a_never_busy, busy)

endmodule

bind barometric_pressure_compensation_unit bpc_port_props u_bpc_props (.*);

@@ sim/bpc_checker.sv @@
module bpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_raw_temp,
  input  logic [15:0] in_raw_pres,
  input  logic        out_valid,
  input  logic [31:0] out_temp_tenths,
  input  logic [31:0] out_pressure_pa,
  input  logic        out_div_error,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          errors_seen
);

  typedef struct packed {
    logic [31:0] temp_tenths;
    logic [31:0] pressure_pa;
    logic        div_error;
  } reading_t;

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mb_mc;
  logic [15:0] md_word;
  reading_t    expected_readings[$];

  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // Signed division truncating towards zero; the most negative value over minus one wraps.
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [15:0] ut, input logic [15:0] up);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den;
    ac1 = {{16{ac1_ac2[31]}}, ac1_ac2[31:16]};
    ac2 = {{16{ac1_ac2[15]}}, ac1_ac2[15:0]};
    ac3 = {{16{ac3_ac4[31]}}, ac3_ac4[31:16]};
    ac4 = {16'd0, ac3_ac4[15:0]};
    ac5 = {16'd0, ac5_ac6[31:16]};
    ac6 = {16'd0, ac5_ac6[15:0]};
    b1  = {{16{b1_b2[31]}}, b1_b2[31:16]};
    b2  = {{16{b1_b2[15]}}, b1_b2[15:0]};
    mc  = {{16{mb_mc[15]}}, mb_mc[15:0]};
    md  = {{16{md_word[15]}}, md_word};
    r = '{32'd0, 32'd0, 1'b1};
    x1 = shr_arith(({16'd0, ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    r.temp_tenths = shr_arith(b5 + 32'd8, 4);
    b6 = b5 - bpc_pkg::C_4000;
    sq = shr_arith(b6 * b6, 12);
    x1 = shr_arith(b2 * sq, 11);
    x2 = shr_arith(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
    x1 = shr_arith(ac3 * b6, 13);
    x2 = shr_arith(b1 * sq, 16);
    x3 = shr_arith(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::C_32768)) >> 15;
    if (b4 == 32'd0) begin
      r.temp_tenths = 32'd0;
      return r;
    end
    b7 = ({16'd0, up} - b3) * bpc_pkg::C_50000;
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = shr_arith(p, 8) * shr_arith(p, 8);
    x1 = shr_arith(x1 * bpc_pkg::C_3038, 16);
    x2 = shr_arith(bpc_pkg::C_NEG_7357 * p, 16);
    p = p + shr_arith(x1 + x2 + bpc_pkg::C_3791, 4);
    r.pressure_pa = p;
    r.div_error = 1'b0;
    return r;
  endfunction

  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      ac1_ac2 <= '0; ac3_ac4 <= '0; ac5_ac6 <= '0; b1_b2 <= '0; mb_mc <= '0; md_word <= '0;
      expected_readings.delete();
      fail_count <= 0;
      results_seen <= 0;
      errors_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (bpc_pkg::cfg_reg_t'(cfg_index))
          bpc_pkg::REG_AC1_AC2: ac1_ac2 <= cfg_wdata;
          bpc_pkg::REG_AC3_AC4: ac3_ac4 <= cfg_wdata;
          bpc_pkg::REG_AC5_AC6: ac5_ac6 <= cfg_wdata;
          bpc_pkg::REG_B1_B2:   b1_b2 <= cfg_wdata;
          bpc_pkg::REG_MB_MC:   mb_mc <= cfg_wdata;
          bpc_pkg::REG_MD:      md_word <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (out_div_error) errors_seen <= errors_seen + 1;
        if (expected_readings.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_readings.pop_front();
          if (want.temp_tenths !== out_temp_tenths || want.pressure_pa !== out_pressure_pa ||
              want.div_error !== out_div_error) begin
            if (fail_count < 10)
              $display("mismatch: expected t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                       $signed(want.temp_tenths), $signed(want.pressure_pa), want.div_error,
                       $signed(out_temp_tenths), $signed(out_pressure_pa), out_div_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Registers are stable while a transaction is accepted, so the current copy is used.
      if (start && !busy) expected_readings.push_back(compensate(in_raw_temp, in_raw_pres));
    end
  end

endmodule

@@ sim/tb_barometric_pressure_compensation_unit.sv @@
module tb_barometric_pressure_compensation_unit;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_raw_temp = '0;
  logic [15:0] in_raw_pres = '0;
  logic        out_valid;
  logic signed [31:0] out_temp_tenths, out_pressure_pa;
  logic        out_div_error;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count, pending, results_seen, errors_seen;
  int          items_sent = 0;

  always #4 clk = ~clk;

  barometric_pressure_compensation_unit dut (.*);

  bpc_checker checker_i (.*);

  task automatic write_reg(input bpc_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calibration(input logic [31:0] v0, v1, v2, v3, v4, v5);
    write_reg(bpc_pkg::REG_AC1_AC2, v0);
    write_reg(bpc_pkg::REG_AC3_AC4, v1);
    write_reg(bpc_pkg::REG_AC5_AC6, v2);
    write_reg(bpc_pkg::REG_B1_B2, v3);
    write_reg(bpc_pkg::REG_MB_MC, v4);
    write_reg(bpc_pkg::REG_MD, v5);
  endtask

  // Start stays high across back-to-back transactions and drops only for a real gap.
  task automatic send_reading(input logic [15:0] ut, input logic [15:0] up, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_raw_temp <= ut;
    in_raw_pres <= up;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (bpc_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_random(input int count, input bit idle);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0)
        send_reading($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF, 16'($urandom), idle);
      else
        send_reading(16'($urandom), 16'($urandom), idle);
    end
  endtask

  logic [31:0] datasheet_cal[6] = '{{16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                                    {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                                    {-16'sd32768, -16'sd8711}, 32'd2868};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero calibration: every transaction must report a zero divisor.
    send_reading(16'h0000, 16'h0000, 1'b0);
    send_reading(16'hFFFF, 16'hFFFF, 1'b0);
    drain();

    load_calibration(datasheet_cal[0], datasheet_cal[1], datasheet_cal[2],
                     datasheet_cal[3], datasheet_cal[4], datasheet_cal[5]);
    send_reading(16'd27898, 16'd23843, 1'b0);
    send_reading(16'h0000, 16'h0000, 1'b0);
    send_reading(16'hFFFF, 16'hFFFF, 1'b0);
    send_reading(16'h0000, 16'hFFFF, 1'b1);
    send_reading(16'hFFFF, 16'h0000, 1'b1);
    send_reading(16'h8000, 16'h7FFF, 1'b1);
    send_reading(16'd23153, 16'd0, 1'b0);
    drain();

    // Temperature divisor cancels: ac5 zero so x1 is zero, and md zero.
    load_calibration(datasheet_cal[0], datasheet_cal[1], 32'h0000_5A71, datasheet_cal[3],
                     datasheet_cal[4], 32'd0);
    send_reading(16'd1234, 16'd40000, 1'b0);
    drain();
    // Pressure divisor zero: ac4 zero.
    write_reg(bpc_pkg::REG_MD, 32'd2868);
    write_reg(bpc_pkg::REG_AC3_AC4, 32'hC7D1_0000);
    send_reading(16'd27898, 16'd23843, 1'b0);
    drain();

    // Extremes: wrapping, the most negative quotient and the large-b7 path.
    load_calibration(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_FFFF, 32'h8000_8000,
                     32'hFFFF_8000, 32'h0000_8000);
    send_reading(16'h0000, 16'h0000, 1'b0);
    send_reading(16'hFFFF, 16'hFFFF, 1'b0);
    send_random(8, 1'b0);
    drain();
    load_calibration(32'h7FFF_7FFF, 32'h7FFF_0001, 32'h0001_0001, 32'h7FFF_7FFF,
                     32'h0000_7FFF, 32'h0000_7FFF);
    send_random(8, 1'b1);
    drain();

    // Random phases: mostly realistic calibration nudged at random, some fully random.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 2)
        load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_calibration(datasheet_cal[0] ^ $urandom_range(0, 255),
                         datasheet_cal[1] ^ $urandom_range(0, 255),
                         datasheet_cal[2] ^ $urandom_range(0, 255),
                         datasheet_cal[3] ^ $urandom_range(0, 255),
                         datasheet_cal[4] ^ $urandom, datasheet_cal[5] ^ $urandom_range(0, 255));
      send_random(50, 1'b0);
      send_random(55, 1'b1);
      drain();
    end

    $display("Sent %0d readings over 16 calibration settings; %0d results, %0d with divisor error.",
             items_sent, results_seen, errors_seen);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/barometric_pressure_compensation_unit.sv
sv/bpc_checker.sv
sim/bpc_checker.sv
sim/tb_barometric_pressure_compensation_unit.sv
